/* rtl/core/lprd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprd_pkg: shared definitions for the length-prefixed request deframer
// Section codes, length field sizes and the state and result records that
// pass between the top level and the byte step logic.
// ----------------------------------------------------------------------------
package lprd_pkg;

    localparam int DataWidth = 8;
    localparam int LenWidth  = 32;

    // Section codes as they appear on the result.
    localparam logic [2:0] SEC_PATH_LEN = 3'd0;
    localparam logic [2:0] SEC_PATH     = 3'd1;
    localparam logic [2:0] SEC_HDR_LEN  = 3'd2;
    localparam logic [2:0] SEC_HDR      = 3'd3;
    localparam logic [2:0] SEC_PAY_LEN  = 3'd4;
    localparam logic [2:0] SEC_PAY      = 3'd5;

    // Number of bytes in the short (path, headers) and long (payload) length fields.
    localparam logic [2:0] SHORT_LEN_BYTES = 3'd2;
    localparam logic [2:0] LONG_LEN_BYTES  = 3'd4;

    typedef struct packed {
        logic [2:0]          section;
        logic [1:0]          len_cnt;
        logic [LenWidth-1:0] len_acc;
        logic [LenWidth-1:0] remaining;
    } t_state;

    typedef struct packed {
        logic [DataWidth-1:0] byte_out;
        logic [2:0]           section;
        logic                 section_last;
        logic                 frame_last;
        logic [LenWidth-1:0]  decoded_length;
    } t_result;

endpackage

/* rtl/core/lprd_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprd_step: per-byte parse logic
// Given the parser state and one stream byte, forms the tagged result and
// the state that follows the byte.
// ----------------------------------------------------------------------------
module lprd_step (
    input  lprd_pkg::t_state                       i_state,
    input  logic [lprd_pkg::DataWidth-1:0]         i_data_byte,
    output lprd_pkg::t_state                       o_next,
    output lprd_pkg::t_result                      o_result
);
    import lprd_pkg::*;

    logic [2:0]          sec;
    logic                is_len;
    logic [2:0]          need;
    logic [2:0]          cnt;
    logic [LenWidth-1:0] acc;
    logic [LenWidth-1:0] len;

    always_comb begin
        // Codes above the payload section never occur; treat them as a path length byte.
        sec    = (i_state.section > SEC_PAY) ? SEC_PATH_LEN : i_state.section;
        is_len = (sec == SEC_PATH_LEN) || (sec == SEC_HDR_LEN) || (sec == SEC_PAY_LEN);
        need   = (sec == SEC_PAY_LEN) ? LONG_LEN_BYTES : SHORT_LEN_BYTES;
        cnt    = {1'b0, i_state.len_cnt} + 3'd1;
        acc    = {i_state.len_acc[LenWidth-DataWidth-1:0], i_data_byte};
        len    = (sec == SEC_PAY_LEN) ? acc : {16'd0, acc[15:0]};

        o_next                  = i_state;
        o_next.section          = sec;
        o_result.byte_out       = i_data_byte;
        o_result.section        = sec;
        o_result.section_last   = 1'b0;
        o_result.frame_last     = 1'b0;
        o_result.decoded_length = '0;

        if (is_len) begin
            if (cnt >= need) begin
                o_result.section_last   = 1'b1;
                o_result.decoded_length = len;
                o_next.len_cnt          = '0;
                o_next.len_acc          = '0;
                o_next.remaining        = len;
                if (len != '0) begin
                    o_next.section = sec + 3'd1;
                end else if (sec == SEC_PAY_LEN) begin
                    // Empty payload: the length field closes the frame.
                    o_result.frame_last = 1'b1;
                    o_next.section      = SEC_PATH_LEN;
                end else begin
                    // Empty path or headers: skip straight to the next length field.
                    o_next.section = sec + 3'd2;
                end
            end else begin
                o_next.len_cnt = cnt[1:0];
                o_next.len_acc = acc;
            end
        end else begin
            if (i_state.remaining[LenWidth-1:1] == '0) begin
                o_result.section_last = 1'b1;
                o_next.remaining      = '0;
                o_next.len_cnt        = '0;
                o_next.len_acc        = '0;
                if (sec == SEC_PAY) begin
                    o_result.frame_last = 1'b1;
                    o_next.section      = SEC_PATH_LEN;
                end else begin
                    o_next.section = sec + 3'd1;
                end
            end else begin
                o_next.remaining = i_state.remaining - 32'd1;
            end
        end
    end

endmodule

/* rtl/core/length_prefixed_request_deframer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_request_deframer: tags a framed request byte stream
// Each frame is a 2-byte path length, the path, a 2-byte headers length,
// the headers, a 4-byte payload length and the payload, all big-endian.
//
// Usage: bytes enter on the input channel (i_valid, o_stall, i_data_byte),
// one beat per byte. Each input beat yields exactly one output beat
// (o_valid, i_stall, o_* fields) carrying the byte, its section code, flags
// for the last byte of the section and of the frame, and the decoded length
// on the final byte of a length field. Sections of zero length produce no
// beats; the length field that announced them moves on past them.
// A byte moves from the input register through the combinational parse step
// (ending in the 32-bit remaining-count decrement) into the result register.
// Throughput is one byte per clock while the receiver does not stall.
// When the receiver stalls, the result register holds its beat; the input
// register still takes one more byte, after which o_stall rises until the
// result drains. Reset (synchronous, active low) empties both registers and
// returns the parser to the start of a frame's path length field.
// ----------------------------------------------------------------------------
module length_prefixed_request_deframer (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Input byte channel
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [lprd_pkg::DataWidth-1:0]         i_data_byte,
    // Output result channel
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [lprd_pkg::DataWidth-1:0]         o_byte_out,
    output logic [2:0]                             o_section,
    output logic                                   o_section_last,
    output logic                                   o_frame_last,
    output logic [lprd_pkg::LenWidth-1:0]          o_decoded_length
);
    import lprd_pkg::*;

    // Input register stage.
    logic                 r_in_valid, n_in_valid;
    logic [DataWidth-1:0] r_in_byte;

    // Result register stage.
    logic    r_out_valid, n_out_valid;
    t_result r_result;

    // Parser state, updated when a byte moves into the result register.
    t_state  r_state;
    t_state  step_next;
    t_result step_result;

    logic out_free;
    logic advance;
    logic in_take;

    // The result register can load when it is empty or its beat leaves now.
    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    lprd_step u_step (
        .i_state     (r_state),
        .i_data_byte (r_in_byte),
        .o_next      (step_next),
        .o_result    (step_result)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state and parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_state.section   <= SEC_PATH_LEN;
            r_state.len_cnt   <= '0;
            r_state.len_acc   <= '0;
            r_state.remaining <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (advance) begin
                r_state <= step_next;
            end
        end
    end

    // Payload registers hold while stalled.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
        end
        if (advance) begin
            r_result <= step_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_byte_out       = r_result.byte_out;
    assign o_section        = r_result.section;
    assign o_section_last   = r_result.section_last;
    assign o_frame_last     = r_result.frame_last;
    assign o_decoded_length = r_result.decoded_length;

endmodule
